// ===== rtl/core/spq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

   // Defaults for the top-level parameters.
   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   // Fixed port widths.
   localparam int OPCODE_W    = 1;
   localparam int DATA_W      = 32;
   localparam int PORT_PRIO_W = 8;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_AHEAD = 3'd0,
      ST_END   = 3'd1,
      ST_FULL  = 3'd2,
      ST_DEQ   = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // update the cell array and the result registers
   } ctrl_cmd_type;

endpackage : spq_pkg
`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spq_ctrl
// Sequencer: capture a request, run the update, present the result.
// ---------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   output      logic         rsp_valid,
   output      ctrl_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            // A new item may be taken while the result is on the ports.
            rsp_valid = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule : spq_ctrl
`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spq_datapath
// Row of sorted cells with parallel compare, shift insert and shift remove.
// ---------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic signed [DATA_W-1:0] req_entry_data,
   input  wire logic [PORT_PRIO_W-1:0]   req_entry_priority,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic [PORT_PRIO_W-1:0]   rsp_out_priority,
   output      logic signed [DATA_W-1:0] rsp_out_data,
   output      logic [OCC_W-1:0]         rsp_occupancy
);

   // Stored priority width: only the low PRIORITY_BITS of the port are used.
   localparam int SW = (PRIORITY_BITS < PORT_PRIO_W) ? PRIORITY_BITS : PORT_PRIO_W;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Captured request.
   opcode_type         op_ff;
   logic [DATA_W-1:0]  data_ff;
   logic [SW-1:0]      prio_ff;

   // Cell array and fill count.
   logic [SW-1:0]      cell_prio_ff [QUEUE_DEPTH];
   logic [SW-1:0]      cell_prio_in [QUEUE_DEPTH];
   logic [DATA_W-1:0]  cell_data_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0]  cell_data_in [QUEUE_DEPTH];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   // Result registers.
   status_type         status_ff;
   status_type         status_in;
   logic [SW-1:0]      out_prio_ff;
   logic [SW-1:0]      out_prio_in;
   logic [DATA_W-1:0]  out_data_ff;
   logic [DATA_W-1:0]  out_data_in;

   logic [QUEUE_DEPTH-1:0] gt_v;
   logic [QUEUE_DEPTH-1:0] open_v;
   logic [QUEUE_DEPTH-1:0] prev_open_v;
   logic                   full;
   logic                   empty;
   logic                   do_enq;
   logic                   do_deq;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         data_ff <= req_entry_data;
         prio_ff <= req_entry_priority[SW-1:0];
      end
   end

   assign full   = (count_ff == CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign do_enq = cmd.exec && (op_ff == OP_ENQUEUE) && !full;
   assign do_deq = cmd.exec && (op_ff == OP_DEQUEUE) && !empty;

   // An open cell is one at or past the insertion point. Because stored
   // entries are sorted, the open cells form one run up to the end.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      assign gt_v[g]   = (count_ff > CW'(g)) && (cell_prio_ff[g] > prio_ff);
      assign open_v[g] = !(count_ff > CW'(g)) || gt_v[g];

      if (g == 0) begin : g_first
         assign prev_open_v[g] = 1'b0;
      end else begin : g_rest
         assign prev_open_v[g] = open_v[g-1];
      end

      always_comb begin
         cell_prio_in[g] = cell_prio_ff[g];
         cell_data_in[g] = cell_data_ff[g];
         if (do_enq && open_v[g]) begin
            if (!prev_open_v[g]) begin
               cell_prio_in[g] = prio_ff;
               cell_data_in[g] = data_ff;
            end else begin
               cell_prio_in[g] = cell_prio_ff[(g == 0) ? 0 : g-1];
               cell_data_in[g] = cell_data_ff[(g == 0) ? 0 : g-1];
            end
         end else if (do_deq) begin
            cell_prio_in[g] = cell_prio_ff[(g == QUEUE_DEPTH-1) ? g : g+1];
            cell_data_in[g] = cell_data_ff[(g == QUEUE_DEPTH-1) ? g : g+1];
         end
      end

      always_ff @(posedge clock) begin
         cell_prio_ff[g] <= cell_prio_in[g];
         cell_data_ff[g] <= cell_data_in[g];
      end
   end

   always_comb begin
      count_in    = count_ff;
      status_in   = status_ff;
      out_prio_in = out_prio_ff;
      out_data_in = out_data_ff;
      if (cmd.exec) begin
         out_prio_in = '0;
         out_data_in = '0;
         unique case (op_ff)
            OP_ENQUEUE: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in  = count_ff + CW'(1);
                  status_in = (|gt_v) ? ST_AHEAD : ST_END;
               end
            end
            OP_DEQUEUE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in    = count_ff - CW'(1);
                  status_in   = ST_DEQ;
                  out_prio_in = cell_prio_ff[0];
                  out_data_in = cell_data_ff[0];
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      out_prio_ff <= out_prio_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_out_priority = PORT_PRIO_W'(out_prio_ff);
   assign rsp_out_data     = out_data_ff;
   assign rsp_occupancy    = OCC_W'(count_ff);

endmodule : spq_datapath
`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending priority order in a row of cells.
// ---------------------------------------------------------------------------
// Flow: an accepted item is captured, the cell row updates in the EXEC state and
// the result strobe is shown in the RESP state that follows.
// The block takes no new item during the update; the next item is taken in the
// same cycle as the result strobe.
// Results cannot be held off, so nothing else ever stalls the block.
// Reset clears the controller and the entry count; cell contents are not
// cleared and are never read before they are written.
// ---------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic signed [DATA_W-1:0] req_entry_data,
   input  wire logic [PORT_PRIO_W-1:0]   req_entry_priority,
   output      logic                     rsp_valid,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic [PORT_PRIO_W-1:0]   rsp_out_priority,
   output      logic signed [DATA_W-1:0] rsp_out_data,
   output      logic [OCC_W-1:0]         rsp_occupancy
);

   // The controller sequences each item through capture, update and result;
   // the datapath owns the cells, the entry count and the result registers.
   ctrl_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Every cell compares its priority against the new one in parallel, so an
   // insert or a removal shifts the whole row together. Entries of
   // equal priority stay in arrival order because a new entry only goes
   // ahead of strictly greater priorities.
   spq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req_opcode),
      .req_entry_data     (req_entry_data),
      .req_entry_priority (req_entry_priority),
      .rsp_status         (rsp_status),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_out_data       (rsp_out_data),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule : sorted_priority_queue
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue. A queue of pending items
// feeds a clocked driver. At each accepted item a software copy of the queue
// works out the expected result. A clocked monitor checks each result strobe,
// field by field, against the oldest expected result.
// ---------------------------------------------------------------------------
module testbench
   import spq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int PRIO_BITS    = PRIORITY_BITS_DEF;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 8;

   // One item for the block, as the driver will present it. When
   // wait_for_drain is set, the driver holds the item back until every
   // expected result has arrived.
   typedef struct {
      opcode_type               op;
      logic signed [DATA_W-1:0] data;
      logic [PORT_PRIO_W-1:0]   prio;
      bit                       wait_for_drain;
   } queue_cmd_type;

   // One result as the block should report it.
   typedef struct {
      status_type               status;
      logic [PORT_PRIO_W-1:0]   prio;
      logic signed [DATA_W-1:0] data;
      logic [OCC_W-1:0]         occ;
   } queue_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OPCODE_W-1:0]      req_opcode = OP_ENQUEUE;
   logic signed [DATA_W-1:0] req_entry_data = '0;
   logic [PORT_PRIO_W-1:0]   req_entry_priority = '0;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [PORT_PRIO_W-1:0]   rsp_out_priority;
   logic signed [DATA_W-1:0] rsp_out_data;
   logic [OCC_W-1:0]         rsp_occupancy;

   queue_cmd_type    pending_cmds[$];
   queue_result_type expected_results[$];

   // Software copy of the queue contents. Slot 0 is the head.
   logic [PORT_PRIO_W-1:0]   shadow_prio[DEPTH];
   logic signed [DATA_W-1:0] shadow_data[DEPTH];
   int                       shadow_count = 0;

   int mismatch_count = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int cycle_count    = 0;
   int status_tally[5];

   sorted_priority_queue uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_entry_data     (req_entry_data),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_out_data       (rsp_out_data),
      .rsp_occupancy      (rsp_occupancy)
   );

   always #2 clock = ~clock;

   // Applies one accepted item to the software queue and returns the result
   // the block must report for it.
   function automatic queue_result_type apply_queue_cmd(input queue_cmd_type cmd);
      queue_result_type       res;
      logic [PORT_PRIO_W-1:0] key;
      int                     pos;
      res.status = ST_END;
      res.prio   = '0;
      res.data   = '0;
      key = cmd.prio & PORT_PRIO_W'((64'd1 << PRIO_BITS) - 1);
      if (cmd.op == OP_ENQUEUE) begin
         if (shadow_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // The new entry goes ahead of the first strictly larger priority,
            // so entries of equal priority keep their arrival order.
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_prio[i] > key) begin
                  pos = i;
                  break;
               end
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_data[i] = shadow_data[i-1];
            end
            shadow_prio[pos] = key;
            shadow_data[pos] = cmd.data;
            res.status = (pos < shadow_count) ? ST_AHEAD : ST_END;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.status = ST_DEQ;
         res.prio   = shadow_prio[0];
         res.data   = shadow_data[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1] = shadow_prio[i];
            shadow_data[i-1] = shadow_data[i];
         end
         shadow_count--;
      end
      res.occ = OCC_W'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH result %0d %s: expected %0h, got %0h",
               result_count, field, want, got);
      mismatch_count++;
   endtask

   task automatic queue_cmd(input opcode_type op, input logic [31:0] data,
                            input logic [PORT_PRIO_W-1:0] prio,
                            input bit wait_for_drain = 1'b0);
      queue_cmd_type cmd;
      cmd.op             = op;
      cmd.data           = data;
      cmd.prio           = prio;
      cmd.wait_for_drain = wait_for_drain;
      pending_cmds.push_back(cmd);
   endtask

   // Driver. At each rising edge it first books the item that the block has
   // just accepted, then chooses what to present for the next edge. Every
   // input gets at most one assignment per edge; the request fields keep their values while nothing is offered.
   always @(posedge clock) begin
      bit            offer;
      queue_cmd_type head;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            head = pending_cmds.pop_front();
            expected_results.push_back(apply_queue_cmd(head));
            accepted_count++;
         end
         offer = (pending_cmds.size() != 0);
         if (offer) begin
            head = pending_cmds[0];
            // An item marked for draining waits until nothing is in flight.
            if (head.wait_for_drain && expected_results.size() != 0) begin
               offer = 1'b0;
            end
            // Random gaps, except for a long gap-free window in the middle.
            if ((accepted_count < 500 || accepted_count > 800)
                && $urandom_range(0, 99) < 9) begin
               offer = 1'b0;
            end
         end
         start <= offer;
         if (offer) begin
            req_opcode         <= head.op;
            req_entry_data     <= head.data;
            req_entry_priority <= head.prio;
         end
      end
   end

   // Monitor. A strobe is sampled at the edge that ends its cycle and is
   // compared with the oldest expected result.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         result_count++;
         if (expected_results.size() == 0) begin
            // A strobe with nothing expected counts as one mismatch.
            report_mismatch("unexpected result", 32'd0, 32'(rsp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_out_priority !== want.prio)
               report_mismatch("priority", 32'(want.prio), 32'(rsp_out_priority));
            if (rsp_out_data !== want.data)
               report_mismatch("data", want.data, rsp_out_data);
            if (rsp_occupancy !== want.occ)
               report_mismatch("occupancy", 32'(want.occ), 32'(rsp_occupancy));
            if (want.status <= ST_EMPTY) status_tally[want.status]++;
         end
      end
   end

   // Watchdog. A hung block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int                     enq_bias;
      logic [31:0]            data;
      logic [PORT_PRIO_W-1:0] prio;
      opcode_type             op;

      // Directed part. A dequeue on an empty queue carries extreme values in
      // the fields that a dequeue ignores.
      queue_cmd(OP_DEQUEUE, 32'h7FFF_FFFF, 8'hFF);
      // The first entry lands at the end of an empty queue.
      queue_cmd(OP_ENQUEUE, 32'h8000_0000, 8'hFF);
      queue_cmd(OP_ENQUEUE, 32'h7FFF_FFFF, 8'h00);
      // An equal priority goes behind the entries that already hold it.
      queue_cmd(OP_ENQUEUE, 32'h0000_0000, 8'hFF);
      queue_cmd(OP_ENQUEUE, 32'hFFFF_FFFF, 8'h80);
      queue_cmd(OP_ENQUEUE, 32'h0000_0001, 8'h00);
      // Fill the queue to its last slot with spread priorities.
      for (int i = 0; i < DEPTH - 5; i++) begin
         queue_cmd(OP_ENQUEUE, $urandom, PORT_PRIO_W'(i * 23 + 5));
      end
      // An enqueue into a full queue is turned away.
      queue_cmd(OP_ENQUEUE, 32'hFFFF_FFFF, 8'h00);
      for (int i = 0; i < 4; i++) begin
         queue_cmd(OP_DEQUEUE, $urandom, PORT_PRIO_W'($urandom));
      end

      // Random part. The mix of enqueues and dequeues swings in phases so the
      // queue keeps running full and running dry. Half of the priorities come
      // from a narrow band so that ties are common.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / 80) % 4)
            0:       enq_bias = 85;
            1:       enq_bias = 50;
            2:       enq_bias = 15;
            default: enq_bias = 55;
         endcase
         op = ($urandom_range(0, 99) < enq_bias) ? OP_ENQUEUE : OP_DEQUEUE;
         case ($urandom_range(0, 9))
            0:       data = 32'h8000_0000;
            1:       data = 32'h7FFF_FFFF;
            2:       data = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            default: data = $urandom;
         endcase
         if ($urandom_range(0, 1) == 1) prio = PORT_PRIO_W'($urandom_range(0, 3));
         else                           prio = PORT_PRIO_W'($urandom);
         // Now and then the sender waits for the block to go quiet.
         queue_cmd(op, data, prio, (n % 300) == 0);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d items in %0d cycles.",
               result_count, accepted_count, cycle_count);
      $display("Outcomes: %0d ahead, %0d at end, %0d full, %0d dequeued, %0d empty.",
               status_tally[ST_AHEAD], status_tally[ST_END], status_tally[ST_FULL],
               status_tally[ST_DEQ], status_tally[ST_EMPTY]);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
